/* design/sjt_pkg.sv */
// Shared types, constants and a helper function of the permutation generator.
package sjt_pkg;

  localparam int unsigned NDefault = 8;
  localparam int unsigned StepsWidth = 8;
  localparam int unsigned RankWidth = 16;
  localparam int unsigned ArrWidth = 24;
  localparam int unsigned OutPosWidth = 3;

  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_POS = 2'b01;
  localparam logic [1:0] DIR_NEG = 2'b11;

  typedef struct packed {
    logic [StepsWidth-1:0] steps;
    logic                  zero;
  } cmd_t;

  function automatic logic [RankWidth-1:0] rank_limit(int unsigned n);
    int unsigned f;
    f = 1;
    for (int unsigned i = 2; i <= n; i++) begin
      f = f * i;
      if (f > 65535) begin
        f = 65535;
        break;
      end
    end
    return f[RankWidth-1:0];
  endfunction

endpackage

/* design/sjt_front.sv */
// Front end: accepts step requests, tags empty ones and queues them for the back end.
module sjt_front
  import sjt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [StepsWidth-1:0] steps_i,
  output logic                  cmd_valid_o,
  input  logic                  cmd_ready_i,
  output cmd_t                  cmd_o
);

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;
  cmd_t       new_cmd;

  assign in_ready_o  = (count_q != 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;

  always_comb begin
    new_cmd.steps = steps_i;
    new_cmd.zero  = (steps_i == '0);
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= new_cmd;
    end
  end

endmodule

/* design/sjt_back.sv */
// Back end: carries out the permutation steps and holds the result register.
module sjt_back
  import sjt_pkg::*;
#(
  parameter int unsigned N = NDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_valid_i,
  output logic                   cmd_ready_o,
  input  cmd_t                   cmd_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [ArrWidth-1:0]    arrangement_o,
  output logic [OutPosWidth-1:0] moved_from_o,
  output logic [OutPosWidth-1:0] moved_to_o,
  output logic [RankWidth-1:0]   rank_o,
  output logic                   exhausted_o
);

  localparam int unsigned PW = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned NP = (N < 8) ? N : 8;
  localparam logic [PW-1:0] LAST = PW'(N - 1);
  localparam logic [RankWidth-1:0] LIMIT = rank_limit(N);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_SWAP,
    S_CHECK,
    S_SCAN,
    S_REPORT
  } state_e;

  state_e                state_q, state_d;
  logic [StepsWidth-1:0] steps_q, steps_d;
  logic [PW-1:0]         elem_q [N];
  logic [PW-1:0]         elem_d [N];
  logic [1:0]            dir_q [N];
  logic [1:0]            dir_d [N];
  logic [PW-1:0]         mover_q, mover_d;
  logic [PW-1:0]         top_q, top_d;
  logic [RankWidth-1:0]  rank_q, rank_d;
  logic [PW-1:0]         last_from_q, last_from_d;
  logic [PW-1:0]         last_to_q, last_to_d;
  logic [PW-1:0]         from_q, from_d;
  logic [PW-1:0]         to_q, to_d;
  logic [PW-1:0]         mv_elem_q, mv_elem_d;
  logic [1:0]            mv_dir_q, mv_dir_d;
  logic [PW-1:0]         idx_q, idx_d;
  logic [PW-1:0]         best_q, best_d;
  logic                  found_q, found_d;
  logic                  out_valid_q, out_valid_d;
  logic                  load_out;

  logic [ArrWidth-1:0]    arrangement_q, packed_arr;
  logic [OutPosWidth-1:0] moved_from_q, moved_to_q;
  logic [RankWidth-1:0]   rank_out_q;
  logic                   exhausted_q;

  logic [PW-1:0]         rd_addr;
  logic [PW-1:0]         rd_elem;
  logic [1:0]            rd_dir;
  logic [RankWidth:0]    rank_inc;
  logic signed [PW+1:0]  to_s;
  logic signed [PW+1:0]  nb_s;
  logic                  blocked;
  logic                  step_done;
  logic [PW+2:0]         from_ext, to_ext;

  always_comb begin
    unique case (state_q)
      S_SWAP:  rd_addr = to_q;
      S_CHECK: rd_addr = nb_s[PW-1:0];
      S_SCAN:  rd_addr = idx_q;
      default: rd_addr = mover_q;
    endcase
  end

  assign rd_elem  = elem_q[rd_addr];
  assign rd_dir   = dir_q[rd_addr];
  assign rank_inc = {1'b0, rank_q} + {{RankWidth{1'b0}}, 1'b1};
  assign to_s     = $signed({2'b00, mover_q}) + $signed({{PW{rd_dir[1]}}, rd_dir});
  assign nb_s     = $signed({2'b00, to_q}) + $signed({{PW{mv_dir_q[1]}}, mv_dir_q});
  assign blocked  = (to_q == '0) || (to_q == LAST) || (rd_elem > mv_elem_q);
  assign cmd_ready_o = (state_q == S_IDLE);
  assign load_out = (state_q == S_REPORT) && (!out_valid_q || out_ready_i);

  for (genvar p = 0; p < 8; p++) begin : g_pack
    if (p < NP) begin : g_pos
      logic [PW+2:0] ext;
      assign ext = {3'b000, elem_q[p]};
      assign packed_arr[3*p +: 3] = ext[2:0];
    end else begin : g_pad
      assign packed_arr[3*p +: 3] = 3'b000;
    end
  end

  assign from_ext = {3'b000, last_from_q};
  assign to_ext   = {3'b000, last_to_q};

  always_comb begin
    state_d     = state_q;
    steps_d     = steps_q;
    elem_d      = elem_q;
    dir_d       = dir_q;
    mover_d     = mover_q;
    top_d       = top_q;
    rank_d      = rank_q;
    last_from_d = last_from_q;
    last_to_d   = last_to_q;
    from_d      = from_q;
    to_d        = to_q;
    mv_elem_d   = mv_elem_q;
    mv_dir_d    = mv_dir_q;
    idx_d       = idx_q;
    best_d      = best_q;
    found_d     = found_q;
    out_valid_d = out_valid_q;
    step_done   = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          steps_d = cmd_i.steps;
          state_d = cmd_i.zero ? S_REPORT : S_FETCH;
        end
      end
      S_FETCH: begin
        if (rank_q >= LIMIT) begin
          step_done = 1'b1;
        end else if (rank_inc >= {1'b0, LIMIT}) begin
          rank_d    = LIMIT;
          step_done = 1'b1;
        end else begin
          rank_d = rank_inc[RankWidth-1:0];
          if (to_s < 0 || to_s > $signed({2'b00, LAST})) begin
            step_done = 1'b1;
          end else begin
            from_d    = mover_q;
            to_d      = to_s[PW-1:0];
            mv_elem_d = rd_elem;
            mv_dir_d  = rd_dir;
            state_d   = S_SWAP;
          end
        end
      end
      S_SWAP: begin
        elem_d[from_q] = rd_elem;
        dir_d[from_q]  = rd_dir;
        elem_d[to_q]   = mv_elem_q;
        dir_d[to_q]    = mv_dir_q;
        last_from_d    = from_q;
        last_to_d      = to_q;
        if (mv_elem_q == LAST) begin
          top_d = to_q;
        end else if (rd_elem == LAST) begin
          top_d = from_q;
        end
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (blocked) begin
          dir_d[to_q] = DIR_NONE;
        end
        if (mv_elem_q != LAST) begin
          for (int i = 0; i < N; i++) begin
            if (elem_q[i] > mv_elem_q) begin
              dir_d[i] = (PW'(i) < to_q) ? DIR_POS : DIR_NEG;
            end
          end
          mover_d   = top_q;
          step_done = 1'b1;
        end else if (blocked) begin
          idx_d   = '0;
          found_d = 1'b0;
          state_d = S_SCAN;
        end else begin
          mover_d   = to_q;
          step_done = 1'b1;
        end
      end
      S_SCAN: begin
        if (rd_dir != DIR_NONE && (!found_q || rd_elem > best_q)) begin
          mover_d = idx_q;
          best_d  = rd_elem;
          found_d = 1'b1;
        end
        if (idx_q == LAST) begin
          step_done = 1'b1;
        end else begin
          idx_d = idx_q + PW'(1);
        end
      end
      S_REPORT: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (step_done) begin
      steps_d = steps_q - StepsWidth'(1);
      state_d = (steps_q == StepsWidth'(1)) ? S_REPORT : S_FETCH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      steps_q     <= '0;
      mover_q     <= LAST;
      top_q       <= LAST;
      rank_q      <= '0;
      last_from_q <= '0;
      last_to_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < N; i++) begin
        elem_q[i] <= PW'(i);
        dir_q[i]  <= (i == 0) ? DIR_NONE : DIR_NEG;
      end
    end else begin
      state_q     <= state_d;
      steps_q     <= steps_d;
      mover_q     <= mover_d;
      top_q       <= top_d;
      rank_q      <= rank_d;
      last_from_q <= last_from_d;
      last_to_q   <= last_to_d;
      out_valid_q <= out_valid_d;
      elem_q      <= elem_d;
      dir_q       <= dir_d;
    end
  end

  always_ff @(posedge clk_i) begin
    from_q    <= from_d;
    to_q      <= to_d;
    mv_elem_q <= mv_elem_d;
    mv_dir_q  <= mv_dir_d;
    idx_q     <= idx_d;
    best_q    <= best_d;
    found_q   <= found_d;
    if (load_out) begin
      arrangement_q <= (rank_q >= LIMIT) ? '0 : packed_arr;
      moved_from_q  <= from_ext[2:0];
      moved_to_q    <= to_ext[2:0];
      rank_out_q    <= rank_q;
      exhausted_q   <= (rank_q >= LIMIT);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign arrangement_o = arrangement_q;
  assign moved_from_o  = moved_from_q;
  assign moved_to_o    = moved_to_q;
  assign rank_o        = rank_out_q;
  assign exhausted_o   = exhausted_q;

  a_rank_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rank_q <= LIMIT)
    else $error("Rank went past its limit.");

  a_top_tracks_largest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_FETCH) |-> (elem_q[top_q] == LAST))
    else $error("Tracked position of the largest element is stale.");

  a_mover_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mover_q <= LAST)
    else $error("Next mover points past the last position.");

  a_rank_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWAP) |-> (rank_q == $past(rank_q) + RankWidth'(1)))
    else $error("A swap was started without advancing the rank.");

endmodule

/* design/sjt_permutation_generator.sv */
// Top level of the Steinhaus-Johnson-Trotter permutation generator.
// Each input item on the steps channel (in_valid_i / in_ready_o) asks the block to advance
// the permutation by steps_i positions and then report one result item on the output
// channel (out_valid_o / out_ready_i): the arrangement, the positions of the last swap,
// the rank and the exhausted flag.
// A two-entry queue sits in front of the step engine, so new items are accepted while the
// engine works or while a result waits in the output register.
// An item with zero steps goes from the queue straight to the report state, with no step work.
// Each step passes through fetch, swap and neighbor check with direction update; when the
// largest element runs into an end, the step adds a search for the next mover over the
// direction store, one position per cycle. That is about once in N steps.
// A step taken after exhaustion ends in the fetch state without a swap.
// Once N! (capped at 65535) permutations are reached the rank saturates, the arrangement
// reads zero and further steps change nothing.
// Reset puts the identity arrangement in place, with every element but the first pointing
// down, and clears the rank.
// While the receiver stalls the result holds; the engine finishes its next item and waits,
// and the input queue fills and then drops in_ready_o.
module sjt_permutation_generator
  import sjt_pkg::*;
#(
  parameter int unsigned N = NDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [StepsWidth-1:0]  steps_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [ArrWidth-1:0]    arrangement_o,
  output logic [OutPosWidth-1:0] moved_from_o,
  output logic [OutPosWidth-1:0] moved_to_o,
  output logic [RankWidth-1:0]   rank_o,
  output logic                   exhausted_o
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  sjt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .steps_i     (steps_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  sjt_back #(
    .N (N)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .cmd_i         (cmd),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .arrangement_o (arrangement_o),
    .moved_from_o  (moved_from_o),
    .moved_to_o    (moved_to_o),
    .rank_o        (rank_o),
    .exhausted_o   (exhausted_o)
  );

endmodule

/* test/tb_sjt_permutation_generator.sv */
// Self-checking testbench for the Steinhaus-Johnson-Trotter permutation generator.
`timescale 1ns / 100ps

module tb_sjt_permutation_generator
  import sjt_pkg::*;
();

  localparam int NumElems = NDefault;
  localparam int RandomItems = 1450;
  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles = 50;

  typedef struct {
    logic [ArrWidth-1:0]    arrangement;
    logic [OutPosWidth-1:0] moved_from;
    logic [OutPosWidth-1:0] moved_to;
    logic [RankWidth-1:0]   rank;
    logic                   exhausted;
  } perm_result_t;

  class perm_scoreboard;
    int           elem_at[NumElems];
    int           size_at[NumElems];
    logic [1:0]   dir_at[NumElems];
    int           mover;
    int           perm_rank;
    int           limit;
    int           last_from;
    int           last_to;
    perm_result_t pending[$];
    int           errors;
    int           checked;
    int           exhausted_seen;

    function new();
      limit = 1;
      for (int i = 2; i <= NumElems; i++) begin
        limit = limit * i;
        if (limit > 65535) begin
          limit = 65535;
          break;
        end
      end
      for (int p = 0; p < NumElems; p++) begin
        elem_at[p] = p;
        size_at[p] = p;
        dir_at[p] = (p == 0) ? DIR_NONE : DIR_NEG;
      end
      mover = NumElems - 1;
      perm_rank = 0;
      last_from = 0;
      last_to = 0;
      errors = 0;
      checked = 0;
      exhausted_seen = 0;
    endfunction

    function int dir_offset(logic [1:0] d);
      case (d)
        DIR_POS: return 1;
        DIR_NEG: return -1;
        default: return 0;
      endcase
    endfunction

    function void advance();
      int from_pos;
      int to_pos;
      int best;
      int tmp;
      logic [1:0] tmp_dir;
      logic blocked;
      if (perm_rank >= limit) return;
      perm_rank++;
      if (perm_rank >= limit) begin
        perm_rank = limit;
        return;
      end
      if (mover >= NumElems) return;
      from_pos = mover;
      to_pos = from_pos + dir_offset(dir_at[from_pos]);
      if (to_pos < 0 || to_pos >= NumElems) return;
      tmp = elem_at[from_pos];
      elem_at[from_pos] = elem_at[to_pos];
      elem_at[to_pos] = tmp;
      tmp = size_at[from_pos];
      size_at[from_pos] = size_at[to_pos];
      size_at[to_pos] = tmp;
      tmp_dir = dir_at[from_pos];
      dir_at[from_pos] = dir_at[to_pos];
      dir_at[to_pos] = tmp_dir;
      last_from = from_pos;
      last_to = to_pos;
      if (to_pos == 0 || to_pos == NumElems - 1) begin
        blocked = 1'b1;
      end else begin
        blocked = size_at[to_pos + dir_offset(dir_at[to_pos])] > size_at[to_pos];
      end
      if (blocked) begin
        dir_at[to_pos] = DIR_NONE;
        best = -1;
        for (int i = 0; i < NumElems; i++) begin
          if (dir_at[i] != DIR_NONE && size_at[i] > best) begin
            mover = i;
            best = size_at[i];
          end
        end
      end else begin
        mover = to_pos;
      end
      if (size_at[to_pos] < NumElems - 1) begin
        for (int i = 0; i < NumElems; i++) begin
          if (size_at[i] > size_at[to_pos]) dir_at[i] = (i < to_pos) ? DIR_POS : DIR_NEG;
          if (size_at[i] == NumElems - 1) mover = i;
        end
      end
    endfunction

    function void note_request(logic [StepsWidth-1:0] steps);
      perm_result_t res;
      for (int k = 0; k < int'(steps); k++) advance();
      res.exhausted = perm_rank >= limit;
      res.arrangement = '0;
      if (!res.exhausted) begin
        for (int p = 0; p < NumElems && p < 8; p++) res.arrangement[3*p +: 3] = 3'(elem_at[p]);
      end
      res.moved_from = OutPosWidth'(last_from);
      res.moved_to = OutPosWidth'(last_to);
      res.rank = RankWidth'(perm_rank);
      pending.push_back(res);
    endfunction

    function void check_field(string field, logic [ArrWidth-1:0] want,
                              logic [ArrWidth-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(perm_result_t got);
      perm_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with no request pending, expected none, actual rank %0d",
                 $time, got.rank);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.exhausted) exhausted_seen++;
      check_field("arrangement", want.arrangement, got.arrangement);
      check_field("moved_from", ArrWidth'(want.moved_from), ArrWidth'(got.moved_from));
      check_field("moved_to", ArrWidth'(want.moved_to), ArrWidth'(got.moved_to));
      check_field("rank", ArrWidth'(want.rank), ArrWidth'(got.rank));
      check_field("exhausted", ArrWidth'(want.exhausted), ArrWidth'(got.exhausted));
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [StepsWidth-1:0]  steps_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [ArrWidth-1:0]    arrangement_o;
  logic [OutPosWidth-1:0] moved_from_o;
  logic [OutPosWidth-1:0] moved_to_o;
  logic [RankWidth-1:0]   rank_o;
  logic                   exhausted_o;

  perm_scoreboard sb;
  logic in_burst = 1'b0;
  logic out_burst = 1'b0;
  int   items_sent = 0;
  int   steps_total = 0;

  sjt_permutation_generator uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .steps_i      (steps_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .arrangement_o(arrangement_o),
    .moved_from_o (moved_from_o),
    .moved_to_o   (moved_to_o),
    .rank_o       (rank_o),
    .exhausted_o  (exhausted_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    perm_result_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_request(steps_i);
      if (out_valid_o && out_ready_i) begin
        got.arrangement = arrangement_o;
        got.moved_from = moved_from_o;
        got.moved_to = moved_to_o;
        got.rank = rank_o;
        got.exhausted = exhausted_o;
        sb.check_result(got);
      end
    end
  end

  initial begin : result_sink
    int stall;
    int results_seen;
    results_seen = 0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      results_seen++;
      if (results_seen % 80 == 0) out_burst = !out_burst;
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Timeout: no item moved for %0d cycles.", WatchdogLimit);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_steps(input logic [StepsWidth-1:0] s);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    steps_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    steps_total += int'(s);
  endtask

  initial begin : stimulus
    logic [StepsWidth-1:0] directed[$];
    logic [StepsWidth-1:0] s;
    int pick;
    sb = new();
    directed = '{8'd0, 8'd1, 8'd1, 8'd2, 8'd5, 8'd7, 8'd6, 8'd0, 8'd8, 8'd255,
                 8'd128, 8'd85, 8'd170, 8'd3, 8'd14, 8'd21, 8'd0, 8'd64, 8'd32, 8'd4};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_steps(directed[i]);
    for (int i = 0; i < RandomItems; i++) begin
      if (i % 100 == 0) in_burst = !in_burst;
      pick = $urandom_range(0, 99);
      if (pick < 4) s = 8'd255;
      else if (pick < 10) s = 8'($urandom_range(0, 7));
      else if (pick < 13) s = 8'($urandom_range(0, 255));
      else s = 8'($urandom_range(0, 40));
      send_steps(s);
    end
    while (steps_total < sb.limit) send_steps(8'd255);
    repeat (4) send_steps(8'($urandom_range(0, 255)));
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d step requests asking for %0d advance steps; checked %0d results.",
             items_sent, steps_total, sb.checked);
    $display("Rank reached %0d of %0d; %0d results reported the exhausted state.",
             sb.perm_rank, sb.limit, sb.exhausted_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
